>>> rtl/sm83_ls_pkg.sv
// Shared types, opcode codes and decode function for the SM83 load/store unit.
// No dependencies.
package sm83_ls_pkg;

  // Instruction class after decode
  typedef enum logic [4:0] {
    K_NONE, K_LD_RR, K_LD_R_HL, K_LD_HL_R, K_LD_R_N, K_LD_HL_N, K_LD_PAIR_NN,
    K_LD_SP_NN, K_ST_A_IND, K_LD_A_IND, K_ST_HLI, K_ST_HLD, K_LD_HLI, K_LD_HLD,
    K_ST_SP_NN, K_ST_A_NN, K_LD_A_NN, K_PUSH, K_POP, K_LD_HL_SPE, K_LD_SP_HL
  } kind_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {ST_EXEC, ST_SECOND, ST_FINISH} bstate_e;

  localparam logic [7:0] OP_HALT    = 8'h76;
  localparam logic [7:0] OP_LD_SP   = 8'h31;
  localparam logic [7:0] OP_ST_BC   = 8'h02;
  localparam logic [7:0] OP_ST_DE   = 8'h12;
  localparam logic [7:0] OP_LD_ABC  = 8'h0A;
  localparam logic [7:0] OP_LD_ADE  = 8'h1A;
  localparam logic [7:0] OP_ST_HLI  = 8'h22;
  localparam logic [7:0] OP_ST_HLD  = 8'h32;
  localparam logic [7:0] OP_LD_HLI  = 8'h2A;
  localparam logic [7:0] OP_LD_HLD  = 8'h3A;
  localparam logic [7:0] OP_ST_SPNN = 8'h08;
  localparam logic [7:0] OP_LDH_ST  = 8'hE0;
  localparam logic [7:0] OP_LDH_LD  = 8'hF0;
  localparam logic [7:0] OP_LDC_ST  = 8'hE2;
  localparam logic [7:0] OP_LDC_LD  = 8'hF2;
  localparam logic [7:0] OP_ST_NN   = 8'hEA;
  localparam logic [7:0] OP_LD_NN   = 8'hFA;
  localparam logic [7:0] OP_HL_SPE  = 8'hF8;
  localparam logic [7:0] OP_SP_HL   = 8'hF9;

  localparam logic [7:0]  HIGH_PAGE = 8'hFF;
  localparam logic [7:0]  POP_F_MASK = 8'hF0;
  localparam logic [2:0]  REG_CODE_MEM = 3'd6;

  // Address source chosen at decode time
  typedef enum logic [2:0] {
    A_HL, A_BC, A_DE, A_NN, A_HIGH_N, A_HIGH_C, A_SP
  } asrc_e;

  typedef struct packed {
    kind_e      kind;
    asrc_e      asrc;
    logic [2:0] dst;
    logic [2:0] src;
    logic [1:0] pair;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
  } cmd_t;

  function automatic cmd_t decode(input logic [7:0] op, input logic [7:0] lo,
                                  input logic [7:0] hi);
    cmd_t c;
    c.kind = K_NONE;
    c.asrc = A_HL;
    c.dst = op[5:3];
    c.src = op[2:0];
    c.pair = op[5:4];
    c.imm_low = lo;
    c.imm_high = hi;
    if (op[7:6] == 2'b01) begin
      if (op == OP_HALT) c.kind = K_NONE;
      else if (op[2:0] == REG_CODE_MEM) c.kind = K_LD_R_HL;
      else if (op[5:3] == REG_CODE_MEM) c.kind = K_LD_HL_R;
      else c.kind = K_LD_RR;
    end else if ((op & 8'hC7) == 8'h06) begin
      c.kind = (op[5:3] == REG_CODE_MEM) ? K_LD_HL_N : K_LD_R_N;
    end else begin
      case (op)
        8'h01, 8'h11, 8'h21: c.kind = K_LD_PAIR_NN;
        OP_LD_SP:   c.kind = K_LD_SP_NN;
        OP_ST_BC:   begin c.kind = K_ST_A_IND; c.asrc = A_BC; end
        OP_ST_DE:   begin c.kind = K_ST_A_IND; c.asrc = A_DE; end
        OP_LD_ABC:  begin c.kind = K_LD_A_IND; c.asrc = A_BC; end
        OP_LD_ADE:  begin c.kind = K_LD_A_IND; c.asrc = A_DE; end
        OP_ST_HLI:  c.kind = K_ST_HLI;
        OP_ST_HLD:  c.kind = K_ST_HLD;
        OP_LD_HLI:  c.kind = K_LD_HLI;
        OP_LD_HLD:  c.kind = K_LD_HLD;
        OP_ST_SPNN: begin c.kind = K_ST_SP_NN; c.asrc = A_NN; end
        OP_LDH_ST:  begin c.kind = K_ST_A_IND; c.asrc = A_HIGH_N; end
        OP_LDH_LD:  begin c.kind = K_LD_A_IND; c.asrc = A_HIGH_N; end
        OP_LDC_ST:  begin c.kind = K_ST_A_IND; c.asrc = A_HIGH_C; end
        OP_LDC_LD:  begin c.kind = K_LD_A_IND; c.asrc = A_HIGH_C; end
        OP_ST_NN:   begin c.kind = K_ST_A_IND; c.asrc = A_NN; end
        OP_LD_NN:   begin c.kind = K_LD_A_IND; c.asrc = A_NN; end
        8'hC5, 8'hD5, 8'hE5, 8'hF5: begin c.kind = K_PUSH; c.asrc = A_SP; end
        8'hC1, 8'hD1, 8'hE1, 8'hF1: begin c.kind = K_POP; c.asrc = A_SP; end
        OP_HL_SPE:  c.kind = K_LD_HL_SPE;
        OP_SP_HL:   c.kind = K_LD_SP_HL;
        default:    c.kind = K_NONE;
      endcase
    end
    return c;
  endfunction

endpackage

>>> rtl/sm83_ls_front.sv
// Front end: accepts instruction items, decodes them and queues commands.
// Depends on sm83_ls_pkg.
module sm83_ls_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // opcode, imm_low, imm_high
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output sm83_ls_pkg::cmd_t    cmd_o
);
  import sm83_ls_pkg::*;

  // two-entry command queue
  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= decode(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                        s_axis_tdata[23:16]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("full queue lost entry");
endmodule

>>> rtl/sm83_ls_back.sv
// Back end: register file, 64 KiB data memory and execution sequencer.
// Depends on sm83_ls_pkg.
module sm83_ls_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  sm83_ls_pkg::cmd_t cmd_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [114:0]      res_o
);
  import sm83_ls_pkg::*;

  logic [7:0]  regs_q [8];
  logic [15:0] sp_q;
  logic [7:0]  dmem [65536];
  logic [7:0]  rdata_q;
  logic [7:0]  rlow_q;

  bstate_e     state_q, state_d;
  logic        out_v_q;
  logic [114:0] out_q;

  logic        out_free;
  logic [15:0] bc, de, hl, nn, addr, addr1, pair_val;
  logic [2:0]  pix;
  logic        mem_we, mem_re;
  logic [15:0] mem_a;
  logic [7:0]  mem_wd;
  logic        fin;
  logic [1:0]  wcnt;
  logic [15:0] waddr;
  logic [7:0]  wfirst, wsecond;
  logic [7:0]  nr [8];
  logic [15:0] nsp;
  logic        sup;
  logic [8:0]  sum_lo;
  logic [4:0]  sum_nib;
  logic [15:0] spe;

  function automatic logic [2:0] code_ix(input logic [2:0] c);
    case (c)
      3'd0: return 3'd2;
      3'd1: return 3'd3;
      3'd2: return 3'd4;
      3'd3: return 3'd5;
      3'd4: return 3'd6;
      3'd5: return 3'd7;
      default: return 3'd0;
    endcase
  endfunction

  assign bc = {regs_q[2], regs_q[3]};
  assign de = {regs_q[4], regs_q[5]};
  assign hl = {regs_q[6], regs_q[7]};
  assign nn = {cmd_i.imm_high, cmd_i.imm_low};
  assign pix = {cmd_i.pair == 2'd3 ? 2'd0 : cmd_i.pair + 2'd1, 1'b0};
  assign pair_val = {regs_q[pix], regs_q[pix + 3'd1]};
  assign out_free = !out_v_q || res_ready_i;

  always_comb begin
    case (cmd_i.asrc)
      A_BC:     addr = bc;
      A_DE:     addr = de;
      A_NN:     addr = nn;
      A_HIGH_N: addr = {HIGH_PAGE, cmd_i.imm_low};
      A_HIGH_C: addr = {HIGH_PAGE, regs_q[3]};
      A_SP:     addr = (cmd_i.kind == K_PUSH) ? sp_q - 16'd2 : sp_q;
      default:  addr = hl;
    endcase
  end
  assign addr1 = addr + 16'd1;
  assign sum_lo = {1'b0, sp_q[7:0]} + {1'b0, cmd_i.imm_low};
  assign sum_nib = {1'b0, sp_q[3:0]} + {1'b0, cmd_i.imm_low[3:0]};
  assign spe = sp_q + {{8{cmd_i.imm_low[7]}}, cmd_i.imm_low};

  // Sequencer: ST_EXEC does the first memory access, if any; two-access commands
  // use ST_SECOND; loads finish in ST_FINISH once read data is registered.
  always_comb begin
    state_d = state_q;
    mem_we = 1'b0; mem_re = 1'b0; mem_a = addr; mem_wd = 8'h00;
    fin = 1'b0;
    case (state_q)
      ST_EXEC: if (cmd_valid_i) begin
        case (cmd_i.kind)
          K_LD_R_HL, K_LD_A_IND, K_LD_HLI, K_LD_HLD: begin
            mem_re = 1'b1; state_d = ST_FINISH;
          end
          K_POP: begin mem_re = 1'b1; state_d = ST_SECOND; end
          K_LD_HL_R: begin
            mem_we = out_free; mem_wd = regs_q[code_ix(cmd_i.src)]; fin = out_free;
          end
          K_LD_HL_N: begin mem_we = out_free; mem_wd = cmd_i.imm_low; fin = out_free; end
          K_ST_A_IND, K_ST_HLI, K_ST_HLD: begin
            mem_we = out_free; mem_wd = regs_q[0]; fin = out_free;
          end
          K_ST_SP_NN: begin mem_we = 1'b1; mem_wd = sp_q[7:0]; state_d = ST_SECOND; end
          K_PUSH: begin mem_we = 1'b1; mem_wd = pair_val[7:0]; state_d = ST_SECOND; end
          default: fin = out_free;
        endcase
      end
      ST_SECOND: begin
        mem_a = addr1;
        case (cmd_i.kind)
          K_ST_SP_NN: begin mem_we = out_free; mem_wd = sp_q[15:8]; end
          K_PUSH: begin mem_we = out_free; mem_wd = pair_val[15:8]; end
          default: begin mem_re = 1'b1; end
        endcase
        if (cmd_i.kind == K_POP) state_d = ST_FINISH;
        else begin fin = out_free; if (out_free) state_d = ST_EXEC; end
      end
      ST_FINISH: begin fin = out_free; if (out_free) state_d = ST_EXEC; end
      default: state_d = ST_EXEC;
    endcase
  end

  assign cmd_ready_o = fin;

  // Architectural results of the finishing command
  always_comb begin
    for (int i = 0; i < 8; i++) nr[i] = regs_q[i];
    nsp = sp_q;
    sup = 1'b1;
    wcnt = 2'd0; waddr = 16'h0000; wfirst = 8'h00; wsecond = 8'h00;
    case (cmd_i.kind)
      K_LD_RR: nr[code_ix(cmd_i.dst)] = regs_q[code_ix(cmd_i.src)];
      K_LD_R_HL: nr[code_ix(cmd_i.dst)] = rdata_q;
      K_LD_R_N: nr[code_ix(cmd_i.dst)] = cmd_i.imm_low;
      K_LD_HL_R: begin
        wcnt = 2'd1; waddr = hl; wfirst = regs_q[code_ix(cmd_i.src)];
      end
      K_LD_HL_N: begin wcnt = 2'd1; waddr = hl; wfirst = cmd_i.imm_low; end
      K_LD_PAIR_NN: begin nr[pix] = cmd_i.imm_high; nr[pix + 3'd1] = cmd_i.imm_low; end
      K_LD_SP_NN: nsp = nn;
      K_ST_A_IND: begin wcnt = 2'd1; waddr = addr; wfirst = regs_q[0]; end
      K_LD_A_IND: nr[0] = rdata_q;
      K_ST_HLI, K_ST_HLD: begin
        wcnt = 2'd1; waddr = hl; wfirst = regs_q[0];
        {nr[6], nr[7]} = (cmd_i.kind == K_ST_HLI) ? hl + 16'd1 : hl - 16'd1;
      end
      K_LD_HLI, K_LD_HLD: begin
        nr[0] = rdata_q;
        {nr[6], nr[7]} = (cmd_i.kind == K_LD_HLI) ? hl + 16'd1 : hl - 16'd1;
      end
      K_ST_SP_NN: begin
        wcnt = 2'd2; waddr = nn; wfirst = sp_q[7:0]; wsecond = sp_q[15:8];
      end
      K_PUSH: begin
        wcnt = 2'd2; waddr = addr; wfirst = pair_val[7:0]; wsecond = pair_val[15:8];
        nsp = addr;
      end
      K_POP: begin
        nr[pix] = rdata_q;
        nr[pix + 3'd1] = (cmd_i.pair == 2'd3) ? (rlow_q & POP_F_MASK) : rlow_q;
        nsp = sp_q + 16'd2;
      end
      K_LD_HL_SPE: begin
        nr[1] = {2'b00, sum_nib[4], sum_lo[8], 4'h0};
        {nr[6], nr[7]} = spe;
      end
      K_LD_SP_HL: nsp = hl;
      default: sup = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) dmem[mem_a] <= mem_wd;
    if (mem_re) rdata_q <= dmem[mem_a];
    if (state_q == ST_SECOND) rlow_q <= rdata_q;
    if (fin) out_q <= {nsp, nr[6], nr[7], nr[4], nr[5], nr[2], nr[3], nr[1], nr[0],
                       wsecond, wfirst, waddr, wcnt, sup};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EXEC;
      out_v_q <= 1'b0;
      sp_q <= 16'h0000;
      for (int i = 0; i < 8; i++) regs_q[i] <= 8'h00;
    end else begin
      state_q <= state_d;
      if (fin) begin
        out_v_q <= 1'b1;
        sp_q <= nsp;
        for (int i = 0; i < 8; i++) regs_q[i] <= nr[i];
      end else if (res_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> cmd_valid_i) else $error("finish without command");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !res_ready_i) |=> $stable(out_q)) else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re)) else $error("memory read and write together");
endmodule

>>> rtl/sm83_load_store_unit_core.sv
// Top level of the SM83 load/store unit: decoupled decode front and execute back.
// Depends on sm83_ls_pkg, sm83_ls_front, sm83_ls_back.
// Path: the queue, then back-end states to the result register; register-only
// ops and single stores finish in ST_EXEC, single loads in ST_FINISH, two-byte
// stores in ST_SECOND, POP via ST_SECOND to ST_FINISH (single-port data memory).
// Throughput: one item per cycle for register ops and single stores unless output stalls.
// Reset (async, active low) clears registers, SP, queue and output; memory is not cleared.
module sm83_load_store_unit_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,  // opcode[7:0], imm_low[15:8], imm_high[23:16]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // supported[0], write_count[2:1], write_address[18:3], write_first[26:19],
  // write_second[34:27], a_value[42:35], f_value[50:43], bc_value[66:51],
  // de_value[82:67], hl_value[98:83], sp_value[114:99]; zero padded to 120
  output logic [119:0] m_axis_tdata
);
  import sm83_ls_pkg::*;

  cmd_t         cmd;
  logic         cmd_valid, cmd_ready;
  logic [114:0] res;

  // front: transfer in, decode, queue
  sm83_ls_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  // back: execute against register file and memory, hold result
  sm83_ls_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  // result word is 115 bits; bits above are padding
  assign m_axis_tdata = {5'b00000, res};
endmodule
